### design/vfc_pkg.sv
// Shared types, constants and corner table of the voxel face culling mesher.
package vfc_pkg;

    localparam int CHUNK_WIDTH  = 16;
    localparam int CHUNK_HEIGHT = 128;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_FLOOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE_WALLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_Z  = 3'd5;

    // Face slots in emission order.
    localparam logic [2:0] FACE_ZP = 3'd0;
    localparam logic [2:0] FACE_ZN = 3'd1;
    localparam logic [2:0] FACE_YP = 3'd2;
    localparam logic [2:0] FACE_YN = 3'd3;
    localparam logic [2:0] FACE_XP = 3'd4;
    localparam logic [2:0] FACE_XN = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One classified block as it travels from the front to the back.
    typedef struct packed {
        logic [15:0] world_x;
        logic [6:0]  height;
        logic [15:0] world_z;
        logic [7:0]  block_type;
        logic [7:0]  light;
        logic [5:0]  faces;        // exposed faces, bit 0 is emitted first
        logic        chunk_start;
    } t_item;

    // Corner offsets {dx, dy, dz} for a face slot and corner number.
    function automatic logic [2:0] corner_offset(input logic [2:0] face,
                                                 input logic [1:0] corner);
        logic [2:0] off;
        off = 3'b000;
        unique case (face)
            FACE_ZP: begin
                unique case (corner)
                    2'd0: off = 3'b001;
                    2'd1: off = 3'b101;
                    2'd2: off = 3'b111;
                    default: off = 3'b011;
                endcase
            end
            FACE_ZN: begin
                unique case (corner)
                    2'd0: off = 3'b000;
                    2'd1: off = 3'b010;
                    2'd2: off = 3'b110;
                    default: off = 3'b100;
                endcase
            end
            FACE_YP: begin
                unique case (corner)
                    2'd0: off = 3'b010;
                    2'd1: off = 3'b011;
                    2'd2: off = 3'b111;
                    default: off = 3'b110;
                endcase
            end
            FACE_YN: begin
                unique case (corner)
                    2'd0: off = 3'b000;
                    2'd1: off = 3'b100;
                    2'd2: off = 3'b101;
                    default: off = 3'b001;
                endcase
            end
            FACE_XP: begin
                unique case (corner)
                    2'd0: off = 3'b100;
                    2'd1: off = 3'b110;
                    2'd2: off = 3'b111;
                    default: off = 3'b101;
                endcase
            end
            FACE_XN: begin
                unique case (corner)
                    2'd0: off = 3'b000;
                    2'd1: off = 3'b001;
                    2'd2: off = 3'b011;
                    default: off = 3'b010;
                endcase
            end
            default: off = 3'b000;
        endcase
        return off;
    endfunction

endpackage

### design/vfc_front.sv
// Front end: configuration registers and per-block face classification.
module vfc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_accept,
    input  logic [3:0]                       i_local_x,
    input  logic [6:0]                       i_height,
    input  logic [3:0]                       i_local_z,
    input  logic signed [11:0]               i_chunk_x,
    input  logic signed [11:0]               i_chunk_z,
    input  logic [7:0]                       i_block_type,
    input  logic [7:0]                       i_sky_light_pair,
    input  logic [5:0]                       i_neighbour_mask,
    input  logic                             i_chunk_start,
    output logic                             o_push,
    output vfc_pkg::t_item                   o_item
);

    logic [6:0]         r_height_floor;
    logic               r_hide_walls;
    logic signed [11:0] r_min_chunk_x;
    logic signed [12:0] r_max_chunk_x;
    logic signed [11:0] r_min_chunk_z;
    logic signed [12:0] r_max_chunk_z;

    logic               visible;
    logic [5:0]         occ;
    logic signed [13:0] cx_plus1;
    logic signed [13:0] cz_plus1;
    logic               border_xn;
    logic               border_xp;
    logic               border_zn;
    logic               border_zp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_floor <= 7'd48;
            r_hide_walls   <= 1'b0;
            r_min_chunk_x  <= 12'sd0;
            r_max_chunk_x  <= 13'sd1;
            r_min_chunk_z  <= 12'sd0;
            r_max_chunk_z  <= 13'sd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vfc_pkg::CFG_HEIGHT_FLOOR: r_height_floor <= i_cfg_data[6:0];
                vfc_pkg::CFG_HIDE_WALLS:   r_hide_walls   <= i_cfg_data[0];
                vfc_pkg::CFG_MIN_CHUNK_X:  r_min_chunk_x  <= i_cfg_data[11:0];
                vfc_pkg::CFG_MAX_CHUNK_X:  r_max_chunk_x  <= i_cfg_data;
                vfc_pkg::CFG_MIN_CHUNK_Z:  r_min_chunk_z  <= i_cfg_data[11:0];
                vfc_pkg::CFG_MAX_CHUNK_Z:  r_max_chunk_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cx_plus1 = 14'(i_chunk_x) + 14'sd1;
    assign cz_plus1 = 14'(i_chunk_z) + 14'sd1;

    assign border_xn = (i_local_x == 4'd0)  && (i_chunk_x <= r_min_chunk_x);
    assign border_xp = (i_local_x == 4'd15) && (cx_plus1 >= 14'(r_max_chunk_x));
    assign border_zn = (i_local_z == 4'd0)  && (i_chunk_z <= r_min_chunk_z);
    assign border_zp = (i_local_z == 4'd15) && (cz_plus1 >= 14'(r_max_chunk_z));

    assign visible = (i_block_type != 8'd0) && (i_height >= r_height_floor);

    // Occupancy in the raw bit order: x+, x-, y+, y-, z+, z-.
    always_comb begin
        occ = i_neighbour_mask;
        if (i_height == 7'(vfc_pkg::CHUNK_HEIGHT - 1)) begin
            occ[2] = 1'b0;
        end
        if (i_height <= r_height_floor) begin
            occ[3] = r_hide_walls;
        end
        if (border_zn) begin
            occ[5] = r_hide_walls;
        end
        if (border_zp) begin
            occ[4] = r_hide_walls;
        end
        if (border_xn) begin
            occ[1] = r_hide_walls;
        end
        if (border_xp) begin
            occ[0] = r_hide_walls;
        end
    end

    always_comb begin
        o_item.world_x     = {i_chunk_x, i_local_x};
        o_item.height      = i_height;
        o_item.world_z     = {i_chunk_z, i_local_z};
        o_item.block_type  = i_block_type;
        o_item.light       = i_height[0] ? {i_sky_light_pair[7:4], 4'd0}
                                         : {i_sky_light_pair[3:0], 4'd0};
        o_item.faces       = visible ? ~{occ[1], occ[0], occ[3], occ[2], occ[5], occ[4]}
                                     : 6'd0;
        o_item.chunk_start = i_chunk_start;
    end

    // Blocks with nothing to emit still travel when they restart the counter.
    assign o_push = i_accept && ((o_item.faces != 6'd0) || i_chunk_start);

endmodule

### design/vfc_queue.sv
// Short queue of classified blocks between the front and the back.
module vfc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vfc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output vfc_pkg::t_item o_head
);

    vfc_pkg::t_item                   r_mem [vfc_pkg::QUEUE_DEPTH];
    logic [vfc_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [vfc_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [vfc_pkg::QUEUE_PTR_W:0]    r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == (vfc_pkg::QUEUE_PTR_W+1)'(vfc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/vfc_back.sv
// Back end: walks exposed faces and corners; one vertex per unstalled cycle.
module vfc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  vfc_pkg::t_item i_q_head,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [15:0]    o_vertex_x,
    output logic [7:0]     o_vertex_y,
    output logic [15:0]    o_vertex_z,
    output logic [7:0]     o_vertex_type,
    output logic [7:0]     o_vertex_light,
    output logic [19:0]    o_vertex_index,
    output logic           o_last_vertex
);

    vfc_pkg::t_item r_cur;
    logic [5:0]     r_faces;
    logic [1:0]     r_corner;
    logic [19:0]    r_counter;
    logic           r_out_valid;

    logic [2:0]     face;
    logic [5:0]     faces_left;
    logic [2:0]     off;
    logic           busy;
    logic           emit;
    logic           last;
    logic           load;

    // Lowest remaining face goes first.
    always_comb begin
        face = 3'd0;
        for (int f = 5; f >= 0; f--) begin
            if (r_faces[f]) begin
                face = 3'(f);
            end
        end
    end

    always_comb begin
        faces_left = r_faces;
        faces_left[face] = 1'b0;
    end

    assign off  = vfc_pkg::corner_offset(face, r_corner);
    assign busy = (r_faces != 6'd0);
    assign emit = busy && (!r_out_valid || i_pop);
    assign last = (r_corner == 2'd3) && (faces_left == 6'd0);
    assign load = !i_q_empty && (!busy || (emit && last));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faces     <= 6'd0;
            r_corner    <= 2'd0;
            r_counter   <= 20'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_faces  <= i_q_head.faces;
                r_corner <= 2'd0;
            end else if (emit) begin
                r_corner <= r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    r_faces <= faces_left;
                end
            end

            if (load && i_q_head.chunk_start) begin
                r_counter <= 20'd0;
            end else if (emit) begin
                r_counter <= r_counter + 20'd1;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_vertex_x     <= r_cur.world_x + {15'd0, off[2]};
            o_vertex_y     <= {1'b0, r_cur.height} + {7'd0, off[1]};
            o_vertex_z     <= r_cur.world_z + {15'd0, off[0]};
            o_vertex_type  <= r_cur.block_type;
            o_vertex_light <= r_cur.light;
            o_vertex_index <= r_counter;
            o_last_vertex  <= last;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

### design/voxel_face_cull_mesher.sv
// Top level of the voxel hidden-face culling mesher.
//
// Each input transaction carries one voxel; the block works out which of its
// six faces are not hidden by a neighbour and returns four world-coordinate
// vertices per exposed face, one vertex per output transaction, in the face
// order z+, z-, y+, y-, x+, x-. The last vertex of a voxel has o_last_vertex
// set. Empty voxels and voxels below the height floor return nothing.
// Throughput is set by the vertex sequencer in the back end, which emits one
// vertex per cycle while the output is not stalled; a voxel with no exposed
// face reaches the sequencer only if it restarts the vertex counter.
// A four-entry queue between the classifier and the sequencer lets input
// transactions keep arriving while vertices are still being drained, and
// the output register lets the sequencer run ahead by one vertex of a
// stalled consumer. Configuration registers are written through a separate
// write channel that is always ready; they should be changed only while the
// block is idle. Register indexes: 0 height floor, 1 hide walls, 2 min
// chunk x, 3 max chunk x, 4 min chunk z, 5 max chunk z; other indexes are
// accepted and ignored.
module voxel_face_cull_mesher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Voxel input, queue style.
    input  logic                           push,
    output logic                           full,
    input  logic [3:0]                     i_local_x,
    input  logic [6:0]                     i_height,
    input  logic [3:0]                     i_local_z,
    input  logic signed [11:0]             i_chunk_x,
    input  logic signed [11:0]             i_chunk_z,
    input  logic [7:0]                     i_block_type,
    input  logic [7:0]                     i_sky_light_pair,
    input  logic [5:0]                     i_neighbour_mask,
    input  logic                           i_chunk_start,
    // Vertex output, queue style.
    output logic                           empty,
    input  logic                           pop,
    output logic signed [15:0]             o_vertex_x,
    output logic [7:0]                     o_vertex_y,
    output logic signed [15:0]             o_vertex_z,
    output logic [7:0]                     o_vertex_type,
    output logic [7:0]                     o_vertex_light,
    output logic [19:0]                    o_vertex_index,
    output logic                           o_last_vertex
);

    logic           accept;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    vfc_pkg::t_item front_item;
    vfc_pkg::t_item q_head;
    logic [15:0]    vertex_x;
    logic [15:0]    vertex_z;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    // Classifier: applies the neighbour overrides and packs the voxel.
    vfc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_local_x        (i_local_x),
        .i_height         (i_height),
        .i_local_z        (i_local_z),
        .i_chunk_x        (i_chunk_x),
        .i_chunk_z        (i_chunk_z),
        .i_block_type     (i_block_type),
        .i_sky_light_pair (i_sky_light_pair),
        .i_neighbour_mask (i_neighbour_mask),
        .i_chunk_start    (i_chunk_start),
        .o_push           (q_push),
        .o_item           (front_item)
    );

    // Decoupling queue; the front only pushes voxels that matter downstream.
    vfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Vertex sequencer with its output register.
    vfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_vertex_x     (vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_vertex_z     (vertex_z),
        .o_vertex_type  (o_vertex_type),
        .o_vertex_light (o_vertex_light),
        .o_vertex_index (o_vertex_index),
        .o_last_vertex  (o_last_vertex)
    );

    assign o_vertex_x = $signed(vertex_x);
    assign o_vertex_z = $signed(vertex_z);

endmodule
